@@ rtl/core/stable_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge, suspended while reset is high.
`define SPQ_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("stable_priority_queue: property violated");
// Check a property on every rising clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("stable_priority_queue: property violated");
`else
`define SPQ_ASSERT(lbl, clk_sig, rst_sig, prop)
`define SPQ_ASSERT_ALWAYS(lbl, clk_sig, prop)
`endif

`endif

@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Stable priority queue package
// Entry, command and neighbor link types plus the result status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned IdWidth  = 16;
  localparam int unsigned PriWidth = 8;
  localparam int unsigned OccWidth = 5;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_DEQUEUED = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  // One queued entry
  typedef struct packed {
    logic [IdWidth-1:0]  id;
    logic [PriWidth-1:0] pri;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_cmd_t;

  // What a cell hands to its right-hand neighbor
  typedef struct packed {
    entry_t entry;
    logic   take;
  } cell_link_t;

endpackage

@@ rtl/core/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Stable priority queue cell
// Holds one slot of the sorted row; compares, shifts back or shifts forward.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,     // slot lies below the fill count
  input  spq_pkg::cell_link_t left_link,   // from the cell in front
  input  spq_pkg::entry_t    right_entry,  // entry of the cell behind
  output spq_pkg::cell_link_t link_out
);

  spq_pkg::entry_t entry;
  spq_pkg::entry_t entry_next;
  logic            take;

  // Claim this slot when it is empty or holds a strictly lower priority
  assign take = !occupied || (entry.pri < cmd.new_entry.pri);

  // Pick the new content: insertion point, shift back, shift forward, hold
  always_comb begin
    entry_next = entry;
    if (cmd.enq && take) begin
      entry_next = left_link.take ? left_link.entry : cmd.new_entry;
    end else if (cmd.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign link_out.entry = entry;
  assign link_out.take  = take;

endmodule

@@ rtl/core/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded queue of (id, priority) entries in a sorted row of cells.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries sorted by priority, highest at
// the front; an enqueue lands behind every entry of equal or greater
// priority, so ties leave in arrival order. Every accepted transaction gives
// exactly one result transaction: enqueued, dequeued (with the front entry),
// empty on dequeue, or full with the entry dropped; occupancy is the count
// after the operation, low 5 bits. One transaction is taken per clock: each
// cell compares its own priority against the request and shifts in the same
// cycle, and the result appears in the output register on the next cycle.
// Input is stalled only while that register holds a result not yet taken.
// No clearing pass runs after reset: the fill count alone marks held slots.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] task_id, [23:16] priority_req
  input  logic        s_tuser,   // [0] action (0 enqueue, 1 dequeue)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] out_task_id, [23:16] out_priority,
                                 // [28:24] occupancy, [31:29] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);

  logic [CountWidth-1:0]           count;
  logic [CountWidth-1:0]           count_next;
  logic                            accept;
  logic                            full;
  logic                            empty;
  spq_pkg::cell_cmd_t              cmd;
  spq_pkg::cell_link_t             links [QUEUE_DEPTH];

  logic                            res_valid;
  spq_pkg::status_t                res_status;
  spq_pkg::status_t                res_status_next;
  spq_pkg::entry_t                 res_entry;
  spq_pkg::entry_t                 res_entry_next;
  logic [spq_pkg::OccWidth-1:0]    res_occ;

  // Accept while the output register is free or being drained
  assign s_tready = !res_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CountWidth'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  // Broadcast the operation to the cell row
  always_comb begin
    cmd.enq           = accept && !s_tuser && !full;
    cmd.deq           = accept && s_tuser && !empty;
    cmd.new_entry.id  = s_tdata[15:0];
    cmd.new_entry.pri = s_tdata[23:16];
  end

  // Update the fill count
  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CountWidth'(1);
    end else if (cmd.deq) begin
      count_next = count - CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Build the row of cells, front at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::cell_link_t left_link;
    spq_pkg::entry_t     right_entry;
    logic                occupied;

    assign occupied = (CountWidth'(i) < count);

    if (i == 0) begin : g_front
      assign left_link.entry = '0;
      assign left_link.take  = 1'b0;
    end else begin : g_inner
      assign left_link = links[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign right_entry = links[i].entry;
    end else begin : g_mid
      assign right_entry = links[i+1].entry;
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied),
      .left_link   (left_link),
      .right_entry (right_entry),
      .link_out    (links[i])
    );
  end

  // Form the result of the accepted transaction
  always_comb begin
    res_entry_next = '0;
    if (s_tuser) begin
      if (empty) begin
        res_status_next = spq_pkg::STATUS_EMPTY;
      end else begin
        res_status_next = spq_pkg::STATUS_DEQUEUED;
        res_entry_next  = links[0].entry;
      end
    end else begin
      res_status_next = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_ENQUEUED;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= res_status_next;
      res_entry  <= res_entry_next;
      res_occ    <= spq_pkg::OccWidth'(count_next);
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {3'b000, res_occ, res_entry.pri, res_entry.id};

  // Checks on count, results and ordering
  `SPQ_ASSERT(a_count_bound, clk, rst, count <= CountWidth'(QUEUE_DEPTH))
  `SPQ_ASSERT(a_full_drop, clk, rst,
    (accept && !s_tuser && full) |=> (res_valid && res_status == spq_pkg::STATUS_FULL))
  `SPQ_ASSERT(a_deq_count, clk, rst,
    (accept && s_tuser && !empty) |=> (count == $past(count) - CountWidth'(1)))
  `SPQ_ASSERT(a_front_sorted, clk, rst,
    (count >= CountWidth'(2)) |-> (links[0].entry.pri >= links[1].entry.pri))
  `SPQ_ASSERT(a_count_hold, clk, rst,
    !accept |=> $stable(count))

endmodule
